@@ hdl/imq_pkg.sv @@
// ----------------------------------------------------------------------------
// imq_pkg: shared types and constants for the int8 MAC and requantiser
// Holds the register map, the configuration record and the command and
// status records that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package imq_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   // Register map
   localparam logic [CSR_INDEX_W-1:0] CSR_ACT_OFFSET  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WGT_OFFSET  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_RES_OFFSET  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCALE_MULT  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCALE_SHIFT = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLAMP_LOW   = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLAMP_HIGH  = 3'd6;

   // Reset values
   localparam logic [30:0] SCALE_MULT_RESET = 31'h4000_0000;
   localparam logic [7:0]  CLAMP_LOW_RESET  = 8'h80;
   localparam logic [7:0]  CLAMP_HIGH_RESET = 8'h7F;

   // Round-half-up constant for the Q0.31 product, and its binary point.
   localparam logic [63:0] Q31_ROUND = 64'h0000_0000_4000_0000;
   localparam int          Q31_LSB   = 31;

   typedef struct packed {
      logic [8:0]  act_offset;
      logic [8:0]  wgt_offset;
      logic [7:0]  res_offset;
      logic [30:0] scale_mult;
      logic [5:0]  scale_shift;
      logic [7:0]  clamp_low;
      logic [7:0]  clamp_high;
   } cfg_type;

   typedef struct packed {
      logic capture;
      logic acc_en;
      logic qmul_en;
      logic qrnd_en;
      logic qshf_en;
      logic qofs_en;
      logic out_en;
   } cmd_type;

   typedef struct packed {
      logic last;
   } sts_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ACC,
      ST_QMUL,
      ST_QRND,
      ST_QSHF,
      ST_QOFS,
      ST_QOUT
   } state_type;

endpackage

`default_nettype wire

@@ hdl/imq_if.sv @@
// ----------------------------------------------------------------------------
// imq_if: channel interfaces for the int8 MAC and requantiser
// Request, response and register write channels, each with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface imq_req_if;
   logic               valid;
   logic               ready;
   logic signed [7:0]  act_byte;
   logic signed [7:0]  wgt_byte;
   logic               is_pad;
   logic               is_first;
   logic signed [31:0] bias_value;
   logic               is_last;

   modport source (output valid, act_byte, wgt_byte, is_pad, is_first, bias_value,
                   is_last, input ready);
   modport sink   (input valid, act_byte, wgt_byte, is_pad, is_first, bias_value,
                   is_last, output ready);
endinterface

interface imq_rsp_if;
   logic              valid;
   logic              ready;
   logic signed [7:0] out_value;

   modport source (output valid, out_value, input ready);
   modport sink   (input valid, out_value, output ready);
endinterface

interface imq_csr_if;
   logic                             valid;
   logic                             ready;
   logic [imq_pkg::CSR_INDEX_W-1:0]  index;
   logic [imq_pkg::CSR_DATA_W-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ hdl/int8_mac_requantize.sv @@
// ----------------------------------------------------------------------------
// int8_mac_requantize: int8 dot product with Q0.31 requantisation
// Accumulates offset byte products, then scales, shifts, offsets and clamps.
//
//   Channel   Dir   Handshake      Payload
//   req_chan  in    valid/ready    act_byte, wgt_byte, is_pad, is_first,
//                                  bias_value, is_last
//   rsp_chan  out   valid/ready    out_value
//   csr_chan  in    valid/ready    index (0..6), data
//
// A word without is_last is captured with its offset product, then
// accumulated. A word with is_last then passes through the multiply, round,
// shift and offset stages before its result is registered at the output.
// A waiting result does not stop the next word; a second result stalls in
// the last stage until the response is taken. Reset sets the accumulator to
// zero and the registers to their defaults; the register port is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module int8_mac_requantize (
   input wire logic  clock,
   input wire logic  reset,
   imq_req_if.sink   req_chan,
   imq_rsp_if.source rsp_chan,
   imq_csr_if.sink   csr_chan
);

   imq_pkg::cfg_type cfg;
   imq_pkg::cmd_type cmd;
   imq_pkg::sts_type sts;

   imq_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_chan.valid),
      .csr_ready (csr_chan.ready),
      .csr_index (csr_chan.index),
      .csr_data  (csr_chan.data),
      .cfg       (cfg)
   );

   imq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   imq_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .cmd        (cmd),
      .sts        (sts),
      .act_byte   (req_chan.act_byte),
      .wgt_byte   (req_chan.wgt_byte),
      .is_pad     (req_chan.is_pad),
      .is_first   (req_chan.is_first),
      .bias_value (req_chan.bias_value),
      .is_last    (req_chan.is_last),
      .out_value  (rsp_chan.out_value)
   );

endmodule

`default_nettype wire

@@ hdl/imq_csr.sv @@
// ----------------------------------------------------------------------------
// imq_csr: configuration register file
// Seven registers written through the register channel, always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module imq_csr (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [imq_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [imq_pkg::CSR_DATA_W-1:0]  csr_data,
   output imq_pkg::cfg_type                     cfg
);

   imq_pkg::cfg_type cfg_ff;
   imq_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            imq_pkg::CSR_ACT_OFFSET:  cfg_in.act_offset  = csr_data[8:0];
            imq_pkg::CSR_WGT_OFFSET:  cfg_in.wgt_offset  = csr_data[8:0];
            imq_pkg::CSR_RES_OFFSET:  cfg_in.res_offset  = csr_data[7:0];
            imq_pkg::CSR_SCALE_MULT:  cfg_in.scale_mult  = csr_data[30:0];
            imq_pkg::CSR_SCALE_SHIFT: cfg_in.scale_shift = csr_data[5:0];
            imq_pkg::CSR_CLAMP_LOW:   cfg_in.clamp_low   = csr_data[7:0];
            imq_pkg::CSR_CLAMP_HIGH:  cfg_in.clamp_high  = csr_data[7:0];
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.act_offset  <= '0;
         cfg_ff.wgt_offset  <= '0;
         cfg_ff.res_offset  <= '0;
         cfg_ff.scale_mult  <= imq_pkg::SCALE_MULT_RESET;
         cfg_ff.scale_shift <= '0;
         cfg_ff.clamp_low   <= imq_pkg::CLAMP_LOW_RESET;
         cfg_ff.clamp_high  <= imq_pkg::CLAMP_HIGH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

@@ hdl/imq_datapath.sv @@
// ----------------------------------------------------------------------------
// imq_datapath: multiply-accumulate and requantisation datapath
// Offset product, wrapping accumulator, Q0.31 scaling, shift, offset, clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module imq_datapath (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire imq_pkg::cfg_type   cfg,
   input  wire imq_pkg::cmd_type   cmd,
   output imq_pkg::sts_type        sts,
   input  wire logic signed [7:0]  act_byte,
   input  wire logic signed [7:0]  wgt_byte,
   input  wire logic               is_pad,
   input  wire logic               is_first,
   input  wire logic signed [31:0] bias_value,
   input  wire logic               is_last,
   output logic signed [7:0]       out_value
);

   logic [19:0] prod_ff;
   logic        first_ff;
   logic [31:0] bias_ff;
   logic        last_ff;
   logic [31:0] acc_ff;
   logic [63:0] qprod_ff;
   logic [31:0] scaled_ff;
   logic [31:0] shifted_ff;
   logic [31:0] offs_ff;
   logic [7:0]  out_ff;

   logic [7:0]         act_raw;
   logic signed [9:0]  act_sum;
   logic signed [9:0]  wgt_sum;
   logic signed [19:0] prod_in;
   logic [31:0]        acc_in;
   logic signed [63:0] qprod_in;
   logic [63:0]        qsum;
   logic [31:0]        scaled_in;
   logic [4:0]         right_amt;
   logic [5:0]         left_amt;
   logic [32:0]        rnd_sum;
   logic [32:0]        rnd_shift;
   logic [31:0]        shifted_in;
   logic [31:0]        offs_in;
   logic [31:0]        clamp_lo;
   logic [31:0]        clamp_hi;
   logic [31:0]        clamped;

   assign sts.last  = last_ff;
   assign out_value = out_ff;

   always_comb begin
      // A padded position counts as a raw zero; the offset still applies.
      act_raw  = is_pad ? 8'd0 : act_byte;
      act_sum  = $signed({{2{act_raw[7]}}, act_raw}) +
                 $signed({cfg.act_offset[8], cfg.act_offset});
      wgt_sum  = $signed({{2{wgt_byte[7]}}, wgt_byte}) +
                 $signed({cfg.wgt_offset[8], cfg.wgt_offset});
      prod_in  = act_sum * wgt_sum;

      acc_in   = (first_ff ? bias_ff : acc_ff) + {{12{prod_ff[19]}}, prod_ff};

      qprod_in = $signed(acc_ff) * $signed({1'b0, cfg.scale_mult});
      qsum     = qprod_ff + imq_pkg::Q31_ROUND;
      scaled_in = qsum[imq_pkg::Q31_LSB +: 32];

      right_amt = cfg.scale_shift[4:0];
      left_amt  = 6'(-cfg.scale_shift);
      rnd_sum   = {scaled_ff[31], scaled_ff} + (33'd1 << (right_amt - 5'd1));
      rnd_shift = 33'($signed(rnd_sum) >>> right_amt);
      if (cfg.scale_shift[5]) begin
         // A shift of thirty-two or more leaves nothing behind.
         shifted_in = left_amt[5] ? 32'd0 : (scaled_ff << left_amt[4:0]);
      end else if (right_amt != 5'd0) begin
         shifted_in = rnd_shift[31:0];
      end else begin
         shifted_in = scaled_ff;
      end

      offs_in  = shifted_ff + {{24{cfg.res_offset[7]}}, cfg.res_offset};

      // The upper bound is applied last, so it wins when the bounds cross.
      clamp_lo = {{24{cfg.clamp_low[7]}}, cfg.clamp_low};
      clamp_hi = {{24{cfg.clamp_high[7]}}, cfg.clamp_high};
      clamped  = ($signed(offs_ff) < $signed(clamp_lo)) ? clamp_lo : offs_ff;
      if ($signed(clamped) > $signed(clamp_hi)) begin
         clamped = clamp_hi;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else if (cmd.acc_en) begin
         acc_ff <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         prod_ff  <= prod_in;
         first_ff <= is_first;
         bias_ff  <= bias_value;
         last_ff  <= is_last;
      end
      if (cmd.qmul_en) begin
         qprod_ff <= qprod_in;
      end
      if (cmd.qrnd_en) begin
         scaled_ff <= scaled_in;
      end
      if (cmd.qshf_en) begin
         shifted_ff <= shifted_in;
      end
      if (cmd.qofs_en) begin
         offs_ff <= offs_in;
      end
      if (cmd.out_en) begin
         out_ff <= clamped[7:0];
      end
   end

endmodule

`default_nettype wire

@@ hdl/imq_ctrl.sv @@
// ----------------------------------------------------------------------------
// imq_ctrl: sequencer for the int8 MAC and requantiser
// Steps each word through accumulate and, on the last word, the requantise
// stages; owns the response valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module imq_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output imq_pkg::cmd_type       cmd,
   input  wire imq_pkg::sts_type  sts
);

   imq_pkg::state_type state_ff;
   imq_pkg::state_type state_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;

   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= imq_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         imq_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = imq_pkg::ST_ACC;
            end
         end
         imq_pkg::ST_ACC: begin
            cmd.acc_en = 1'b1;
            state_in   = sts.last ? imq_pkg::ST_QMUL : imq_pkg::ST_IDLE;
         end
         imq_pkg::ST_QMUL: begin
            cmd.qmul_en = 1'b1;
            state_in    = imq_pkg::ST_QRND;
         end
         imq_pkg::ST_QRND: begin
            cmd.qrnd_en = 1'b1;
            state_in    = imq_pkg::ST_QSHF;
         end
         imq_pkg::ST_QSHF: begin
            cmd.qshf_en = 1'b1;
            state_in    = imq_pkg::ST_QOFS;
         end
         imq_pkg::ST_QOFS: begin
            cmd.qofs_en = 1'b1;
            state_in    = imq_pkg::ST_QOUT;
         end
         imq_pkg::ST_QOUT: begin
            // Wait here until the output register is free to take the word.
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_en = 1'b1;
               state_in   = imq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = imq_pkg::ST_IDLE;
         end
      endcase

      if (cmd.out_en) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // A result never overwrites one that is still waiting.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_en |-> (!rsp_valid_ff || rsp_ready))
      else $error("result loaded over a waiting response");

   a_out_shown: assert property (@(posedge clock) disable iff (reset)
      cmd.out_en |=> rsp_valid_ff)
      else $error("loaded result not presented");

   a_plain_word: assert property (@(posedge clock) disable iff (reset)
      (state_ff == imq_pkg::ST_ACC && !sts.last) |=> (state_ff == imq_pkg::ST_IDLE))
      else $error("non-final word entered the requantise stages");

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> (state_ff == imq_pkg::ST_IDLE && !cmd.acc_en))
      else $error("request accepted while a word is in flight");

endmodule

`default_nettype wire
